@@ rtl/fuzzy_dictionary_id_matcher_macros.svh @@
// Assertion macros for the fuzzy dictionary matcher.
// Used by modules that have i_clk and i_rst_n in scope.
`ifndef FUZZY_DICTIONARY_ID_MATCHER_MACROS_SVH
`define FUZZY_DICTIONARY_ID_MATCHER_MACROS_SVH

// same-cycle implication
`define FDM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FDM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fdm_pkg.sv @@
// Shared constants, codes and types of the fuzzy dictionary matcher.
// No dependencies.
package fdm_pkg;

    localparam int MAX_KEYS = 64;
    localparam int MAX_LEN  = 16;
    localparam int KEY_W    = $clog2(MAX_KEYS);
    localparam int CNT_W    = $clog2(MAX_KEYS + 1);
    localparam int LEN_W    = $clog2(MAX_LEN);
    localparam int LCNT_W   = $clog2(MAX_LEN + 1);
    localparam int ADDR_W   = KEY_W + LEN_W;
    localparam int DIST_W   = 5;
    localparam int CFG_W    = 5;
    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W   = $clog2(FIFO_DEPTH);
    localparam int FCNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int PADDR_W  = 4;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_KEY   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [2:0] ST_EXACT   = 3'd0;
    localparam logic [2:0] ST_NORM    = 3'd1;
    localparam logic [2:0] ST_FUZZY   = 3'd2;
    localparam logic [2:0] ST_NOMATCH = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;
    localparam logic [2:0] ST_TOOLONG = 3'd5;
    localparam logic [2:0] ST_REJECT  = 3'd6;

    localparam logic [1:0] REG_SHORT_LEN  = 2'd0;
    localparam logic [1:0] REG_SHORT_DIST = 2'd1;
    localparam logic [1:0] REG_LONG_DIST  = 2'd2;

    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_K = 8'h4B;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_O = 8'h4F;
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_1 = 8'h31;
    localparam logic [7:0] CH_9 = 8'h39;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_Z = 8'h5A;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LZ = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] ch;
        logic       keep;
        logic       last;
    } t_qitem;

    typedef struct packed {
        logic   push;
        t_qitem item;
    } t_qwr;

    typedef struct packed {
        logic [2:0]        status;
        logic              match_valid;
        logic              was_corrected;
        logic [5:0]        key_index;
        logic [DIST_W-1:0] edit_distance;
    } t_result;

    typedef struct packed {
        logic [CFG_W-1:0] short_len;
        logic [CFG_W-1:0] short_dist;
        logic [CFG_W-1:0] long_dist;
    } t_cfg;

endpackage

@@ rtl/fdm_if.sv @@
// Handshake channels of the fuzzy dictionary matcher: input items and results.
// Depends on fdm_pkg.
interface fdm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] character;
    logic       last_byte;
    modport source (output valid, command, character, last_byte, input ready);
    modport sink   (input valid, command, character, last_byte, output ready);
endinterface

interface fdm_out_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                status;
    logic                      match_valid;
    logic                      was_corrected;
    logic [5:0]                key_index;
    logic [fdm_pkg::DIST_W-1:0] edit_distance;
    modport source (output valid, status, match_valid, was_corrected, key_index,
                    edit_distance, input ready);
    modport sink   (input valid, status, match_valid, was_corrected, key_index,
                    edit_distance, output ready);
endinterface

@@ rtl/fdm_front.sv @@
// Front end: takes input items, cleans query bytes and drops items with no effect.
// Depends on fdm_pkg and fdm_if.
module fdm_front (
    fdm_in_if.sink        i_item,
    input  logic          i_full,
    output fdm_pkg::t_qwr o_wr
);
    logic       is_digit;
    logic       is_upper;
    logic       is_lower;
    logic       keep;
    logic [7:0] clean_ch;
    logic       useful;

    assign is_digit = (i_item.character >= fdm_pkg::CH_0) && (i_item.character <= fdm_pkg::CH_9);
    assign is_upper = (i_item.character >= fdm_pkg::CH_A) && (i_item.character <= fdm_pkg::CH_Z);
    assign is_lower = (i_item.character >= fdm_pkg::CH_LA) && (i_item.character <= fdm_pkg::CH_LZ);
    assign keep     = is_digit | is_upper | is_lower;
    assign clean_ch = is_lower ? (i_item.character - fdm_pkg::CASE_OFS) : i_item.character;

    always_comb begin
        case (i_item.command)
            fdm_pkg::CMD_CLEAR: useful = 1'b1;
            fdm_pkg::CMD_KEY:   useful = 1'b1;
            fdm_pkg::CMD_QUERY: useful = keep | i_item.last_byte;
            default:            useful = 1'b0;
        endcase
    end

    assign i_item.ready = !i_full;
    assign o_wr.push      = i_item.valid && !i_full && useful;
    assign o_wr.item.cmd  = i_item.command;
    // keys are stored raw, queries cleaned
    assign o_wr.item.ch   = (i_item.command == fdm_pkg::CMD_QUERY) ? clean_ch : i_item.character;
    assign o_wr.item.keep = keep;
    assign o_wr.item.last = i_item.last_byte;
endmodule

@@ rtl/fdm_fifo.sv @@
// Short queue between front and back ends.
// Depends on fdm_pkg.
module fdm_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fdm_pkg::t_qwr   i_wr,
    input  logic            i_pop,
    output fdm_pkg::t_qitem o_data,
    output logic            o_empty,
    output logic            o_full
);
    fdm_pkg::t_qitem                r_mem [fdm_pkg::FIFO_DEPTH];
    logic [fdm_pkg::FPTR_W-1:0]     r_wptr;
    logic [fdm_pkg::FPTR_W-1:0]     r_rptr;
    logic [fdm_pkg::FCNT_W-1:0]     r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == fdm_pkg::FCNT_W'(fdm_pkg::FIFO_DEPTH));
    assign do_push = i_wr.push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wr.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

@@ rtl/fdm_back.sv @@
// Back end: key table, query buffer, exact and edit-distance search, result register.
// Depends on fdm_pkg, fdm_if and the assertion macros header.
`include "fuzzy_dictionary_id_matcher_macros.svh"
module fdm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fdm_pkg::t_cfg   i_cfg,
    input  fdm_pkg::t_qitem i_item,
    input  logic            i_empty,
    output logic            o_pop,
    fdm_out_if.source       o_result
);
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_QPREP  = 8'b0000_0010,
        S_LOAD   = 8'b0000_0100,
        S_CMP    = 8'b0000_1000,
        S_DP     = 8'b0001_0000,
        S_FINISH = 8'b0010_0000,
        S_ACCEPT = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } t_state;

    localparam int ML = fdm_pkg::MAX_LEN;
    localparam int DW = fdm_pkg::DIST_W;
    localparam int LW = fdm_pkg::LCNT_W;

    t_state r_state;

    logic [7:0]                    key_mem [fdm_pkg::MAX_KEYS * ML];
    logic [LW-1:0]                 len_mem [fdm_pkg::MAX_KEYS];
    logic [7:0]                    r_rd_byte;
    logic [LW-1:0]                 r_rd_len;

    logic [fdm_pkg::CNT_W-1:0]     r_key_count;
    logic [LW-1:0]                 r_load_len;
    logic                          r_load_ovf;
    logic [7:0]                    r_lbuf [ML];
    logic [7:0]                    r_qbuf [ML];
    logic [LW-1:0]                 r_qlen;
    logic                          r_qovf;
    logic [7:0]                    r_norm [ML];
    logic                          r_changed;
    logic [LW-1:0]                 r_n;
    logic                          r_qmode;
    logic [fdm_pkg::KEY_W-1:0]     r_k;
    logic [LW-1:0]                 r_c;
    logic [7:0]                    r_row [ML];
    logic [DW-1:0]                 r_dr [ML + 1];
    logic [LW-1:0]                 r_i;
    logic [LW-1:0]                 r_j;
    logic [DW-1:0]                 r_diag;
    logic [DW-1:0]                 r_left;
    logic [DW-1:0]                 r_best;
    logic [1:0]                    r_tie;
    logic [fdm_pkg::KEY_W-1:0]     r_bidx;
    logic                          r_nfound;
    logic [fdm_pkg::KEY_W-1:0]     r_nidx;
    fdm_pkg::t_result              r_res;
    fdm_pkg::t_result              r_out;
    logic                          r_ov;

    logic                          pop;
    logic                          k_ovf;
    logic                          q_full;
    logic [fdm_pkg::ADDR_W-1:0]    wr_addr;
    logic [fdm_pkg::ADDR_W-1:0]    rd_addr;
    logic                          k_last;
    logic                          mis_q;
    logic                          mis_n;
    logic                          mis_l;
    logic                          eq_q;
    logic                          eq_n;
    logic                          eq_l;
    logic                          pkg_pref;
    logic [7:0]                    n_norm [ML];
    logic                          n_changed;
    logic [LW-1:0]                 i_m1;
    logic [LW-1:0]                 j_m1;
    logic [LW-1:0]                 c_m1;
    logic [DW:0]                   c_up;
    logic [DW:0]                   c_left;
    logic [DW:0]                   c_diag;
    logic [DW:0]                   c_min;
    logic [DW-1:0]                 dp_val;
    logic [DW-1:0]                 limit;

    assign pop     = (r_state == S_IDLE) && !i_empty;
    assign o_pop   = pop;
    assign k_ovf   = r_load_ovf
                   || (r_key_count >= fdm_pkg::CNT_W'(fdm_pkg::MAX_KEYS))
                   || (r_load_len >= LW'(ML));
    assign q_full  = (r_qlen >= LW'(ML));
    assign wr_addr = {r_key_count[fdm_pkg::KEY_W-1:0], r_load_len[fdm_pkg::LEN_W-1:0]};
    assign rd_addr = {r_k, r_c[fdm_pkg::LEN_W-1:0]};
    assign k_last  = (({1'b0, r_k} + 1'b1) == r_key_count);
    // registered read data belongs to the previous value of the byte counter
    assign c_m1    = r_c - 1'b1;

    // masked compares of the loaded key row against query, mapped query, new key
    always_comb begin
        mis_q = 1'b0;
        mis_n = 1'b0;
        mis_l = 1'b0;
        for (int j = 0; j < ML; j++) begin
            if ((LW'(j) < r_n) && (r_row[j] != r_qbuf[j])) mis_q = 1'b1;
            if ((LW'(j) < r_n) && (r_row[j] != r_norm[j])) mis_n = 1'b1;
            if ((LW'(j) < r_load_len) && (r_row[j] != r_lbuf[j])) mis_l = 1'b1;
        end
    end
    assign eq_q = (r_rd_len == r_n) && !mis_q;
    assign eq_n = (r_rd_len == r_n) && !mis_n;
    assign eq_l = (r_rd_len == r_load_len) && !mis_l;

    // PKG prefix letter mapping
    assign pkg_pref = (r_qlen >= LW'(3)) && (r_qbuf[0] == fdm_pkg::CH_P)
                   && (r_qbuf[1] == fdm_pkg::CH_K) && (r_qbuf[2] == fdm_pkg::CH_G);
    always_comb begin
        n_changed = 1'b0;
        for (int j = 0; j < ML; j++) begin
            n_norm[j] = r_qbuf[j];
            if (pkg_pref && (j >= 3) && (LW'(j) < r_qlen)) begin
                if (r_qbuf[j] == fdm_pkg::CH_O) begin
                    n_norm[j] = fdm_pkg::CH_0;
                    n_changed = 1'b1;
                end
                if ((r_qbuf[j] == fdm_pkg::CH_I) || (r_qbuf[j] == fdm_pkg::CH_L)) begin
                    n_norm[j] = fdm_pkg::CH_1;
                    n_changed = 1'b1;
                end
            end
        end
    end

    // one Levenshtein cell per cycle
    assign i_m1   = r_i - 1'b1;
    assign j_m1   = r_j - 1'b1;
    assign c_up   = {1'b0, r_dr[r_j]} + 1'b1;
    assign c_left = {1'b0, r_left} + 1'b1;
    assign c_diag = {1'b0, r_diag}
                  + (DW+1)'(r_norm[i_m1[fdm_pkg::LEN_W-1:0]] != r_row[j_m1[fdm_pkg::LEN_W-1:0]]);
    always_comb begin
        c_min = (c_up < c_left) ? c_up : c_left;
        if (c_diag < c_min) c_min = c_diag;
    end
    assign dp_val = c_min[DW-1:0];
    assign limit  = (r_n <= i_cfg.short_len) ? i_cfg.short_dist : i_cfg.long_dist;

    always_ff @(posedge i_clk) begin
        if (pop && (i_item.cmd == fdm_pkg::CMD_KEY) && !k_ovf) begin
            key_mem[wr_addr] <= i_item.ch;
        end
        if (r_state == S_ACCEPT) begin
            len_mem[r_key_count[fdm_pkg::KEY_W-1:0]] <= r_load_len;
        end
        r_rd_byte <= key_mem[rd_addr];
        r_rd_len  <= len_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key_count <= '0;
            r_load_len  <= '0;
            r_load_ovf  <= 1'b0;
            r_qlen      <= '0;
            r_qovf      <= 1'b0;
            r_ov        <= 1'b0;
            r_best      <= '1;
            r_tie       <= '0;
            r_bidx      <= '0;
            r_nfound    <= 1'b0;
            r_qmode     <= 1'b0;
            r_k         <= '0;
            r_c         <= '0;
        end else begin
            // the emit state sets the flag itself
            if (r_ov && o_result.ready && (r_state != S_EMIT)) begin
                r_ov <= 1'b0;
            end
            if ((r_state == S_LOAD) && (r_c != '0)) begin
                r_row[c_m1[fdm_pkg::LEN_W-1:0]] <= r_rd_byte;
            end
            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        case (i_item.cmd)
                            fdm_pkg::CMD_CLEAR: begin
                                r_key_count <= '0;
                                r_load_len  <= '0;
                                r_load_ovf  <= 1'b0;
                            end
                            fdm_pkg::CMD_KEY: begin
                                if (k_ovf) begin
                                    if (!i_item.last) begin
                                        r_load_ovf <= 1'b1;
                                    end
                                end else begin
                                    r_lbuf[r_load_len[fdm_pkg::LEN_W-1:0]] <= i_item.ch;
                                    r_load_len <= r_load_len + 1'b1;
                                end
                                if (i_item.last) begin
                                    r_qmode <= 1'b0;
                                    r_k     <= '0;
                                    r_c     <= '0;
                                    if (k_ovf) begin
                                        r_load_len <= '0;
                                        r_load_ovf <= 1'b0;
                                        r_res      <= '{fdm_pkg::ST_REJECT, 1'b0, 1'b0,
                                                        6'd0, '0};
                                        r_state    <= S_EMIT;
                                    end else if (r_key_count == '0) begin
                                        r_state <= S_ACCEPT;
                                    end else begin
                                        r_state <= S_LOAD;
                                    end
                                end
                            end
                            fdm_pkg::CMD_QUERY: begin
                                if (i_item.keep) begin
                                    if (q_full) begin
                                        r_qovf <= 1'b1;
                                    end else begin
                                        r_qbuf[r_qlen[fdm_pkg::LEN_W-1:0]] <= i_item.ch;
                                        r_qlen <= r_qlen + 1'b1;
                                    end
                                end
                                if (i_item.last) begin
                                    r_state <= S_QPREP;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_QPREP: begin
                    r_qlen    <= '0;
                    r_qovf    <= 1'b0;
                    r_n       <= r_qlen;
                    r_norm    <= n_norm;
                    r_changed <= n_changed;
                    r_best    <= '1;
                    r_tie     <= '0;
                    r_bidx    <= '0;
                    r_nfound  <= 1'b0;
                    r_qmode   <= 1'b1;
                    r_k       <= '0;
                    r_c       <= '0;
                    if (r_qovf) begin
                        r_res   <= '{fdm_pkg::ST_TOOLONG, 1'b0, 1'b0, 6'd0, '0};
                        r_state <= S_EMIT;
                    end else if (r_qlen == '0) begin
                        r_res   <= '{fdm_pkg::ST_EMPTY, 1'b0, 1'b0, 6'd0, '0};
                        r_state <= S_EMIT;
                    end else if (r_key_count == '0) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_c <= r_c + 1'b1;
                    if (r_c == LW'(ML)) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (!r_qmode) begin
                        if (eq_l) begin
                            r_load_len <= '0;
                            r_load_ovf <= 1'b0;
                            r_res      <= '{fdm_pkg::ST_REJECT, 1'b0, 1'b0, 6'd0, '0};
                            r_state    <= S_EMIT;
                        end else if (k_last) begin
                            r_state <= S_ACCEPT;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_c     <= '0;
                            r_state <= S_LOAD;
                        end
                    end else if (eq_q) begin
                        r_res   <= '{fdm_pkg::ST_EXACT, 1'b1, 1'b0, 6'(r_k), '0};
                        r_state <= S_EMIT;
                    end else begin
                        if (eq_n && r_changed && !r_nfound) begin
                            r_nfound <= 1'b1;
                            r_nidx   <= r_k;
                        end
                        for (int j = 0; j <= ML; j++) begin
                            r_dr[j] <= DW'(j);
                        end
                        r_i     <= LW'(1);
                        r_j     <= '0;
                        r_state <= S_DP;
                    end
                end
                S_DP: begin
                    if (r_j == '0) begin
                        r_diag  <= r_dr[0];
                        r_dr[0] <= DW'(r_i);
                        r_left  <= DW'(r_i);
                        r_j     <= LW'(1);
                    end else begin
                        r_dr[r_j] <= dp_val;
                        r_left    <= dp_val;
                        r_diag    <= r_dr[r_j];
                        if (r_j == r_rd_len) begin
                            r_j <= '0;
                            r_i <= r_i + 1'b1;
                            if (r_i == r_n) begin
                                if (dp_val < r_best) begin
                                    r_best <= dp_val;
                                    r_bidx <= r_k;
                                    r_tie  <= 2'd1;
                                end else if ((dp_val == r_best) && (r_tie != 2'd2)) begin
                                    r_tie <= r_tie + 1'b1;
                                end
                                if (k_last) begin
                                    r_state <= S_FINISH;
                                end else begin
                                    r_k     <= r_k + 1'b1;
                                    r_c     <= '0;
                                    r_state <= S_LOAD;
                                end
                            end
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                S_FINISH: begin
                    if (r_nfound) begin
                        r_res <= '{fdm_pkg::ST_NORM, 1'b1, 1'b1, 6'(r_nidx), '0};
                    end else if ((r_tie == 2'd1) && (r_best <= limit)) begin
                        r_res <= '{fdm_pkg::ST_FUZZY, 1'b1, 1'b1, 6'(r_bidx), r_best};
                    end else begin
                        r_res <= '{fdm_pkg::ST_NOMATCH, 1'b0, 1'b0, 6'd0, r_best};
                    end
                    r_state <= S_EMIT;
                end
                S_ACCEPT: begin
                    r_key_count <= r_key_count + 1'b1;
                    r_load_len  <= '0;
                    r_state     <= S_IDLE;
                end
                S_EMIT: begin
                    if (!r_ov || o_result.ready) begin
                        r_ov    <= 1'b1;
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid         = r_ov;
    assign o_result.status        = r_out.status;
    assign o_result.match_valid   = r_out.match_valid;
    assign o_result.was_corrected = r_out.was_corrected;
    assign o_result.key_index     = r_out.key_index;
    assign o_result.edit_distance = r_out.edit_distance;

    `FDM_ASSERT_IMP(a_count_bound, 1'b1, r_key_count <= fdm_pkg::CNT_W'(fdm_pkg::MAX_KEYS),
        "key count beyond table size")
    `FDM_ASSERT_IMP(a_tie_bound, 1'b1, r_tie != 2'd3, "tie counter past saturation")
    `FDM_ASSERT_IMP(a_match_status, r_ov && r_out.match_valid,
        r_out.status == fdm_pkg::ST_EXACT || r_out.status == fdm_pkg::ST_NORM
        || r_out.status == fdm_pkg::ST_FUZZY, "match flagged with non-match status")
    `FDM_ASSERT_NXT(a_emit_leaves, (r_state == S_EMIT) && !r_ov,
        r_ov && (r_state == S_IDLE), "pending result not moved to output register")
endmodule

@@ rtl/fuzzy_dictionary_id_matcher.sv @@
// Top level of the fuzzy dictionary matcher: APB registers, front, queue, back.
// Depends on fdm_pkg, fdm_if, fdm_front, fdm_fifo and fdm_back.
//
// Input channel i_item carries command (clear, key byte, query byte), a raw
// byte and a last-byte flag; output channel o_result carries one result for
// each query's last byte and for each rejected key. Bytes are taken one per
// cycle into a four-entry queue while not full; a back end drains it one item
// per cycle while idle. A key's last byte scans the table for a duplicate. A
// query's last byte scans each stored key, read over the one-byte-a-cycle key
// memory port, with the single edit-distance cell unit; an exact hit ends the
// scan at that key. Results sit in an output register; while the receiver
// stalls, the back end holds its next result and the queue keeps taking bytes
// until full. Reset empties the table, query and queue and sets the registers
// to short length limit 8, short distance 1, long distance 2; the key memory
// is not cleared, a fill count tracks the valid keys. Registers are written
// over APB at byte addresses 0, 4 and 8; the user must write them only while
// the block is idle, which the block itself does not enforce.
module fuzzy_dictionary_id_matcher (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    fdm_in_if.sink                       i_item,
    fdm_out_if.source                    o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fdm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    fdm_pkg::t_cfg   r_cfg;
    fdm_pkg::t_qwr   wr;
    fdm_pkg::t_qitem q_data;
    logic            q_empty;
    logic            q_full;
    logic            q_pop;
    logic [1:0]      reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_len  <= fdm_pkg::CFG_W'(8);
            r_cfg.short_dist <= fdm_pkg::CFG_W'(1);
            r_cfg.long_dist  <= fdm_pkg::CFG_W'(2);
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                fdm_pkg::REG_SHORT_LEN:  r_cfg.short_len  <= pwdata[fdm_pkg::CFG_W-1:0];
                fdm_pkg::REG_SHORT_DIST: r_cfg.short_dist <= pwdata[fdm_pkg::CFG_W-1:0];
                fdm_pkg::REG_LONG_DIST:  r_cfg.long_dist  <= pwdata[fdm_pkg::CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            fdm_pkg::REG_SHORT_LEN:  prdata = 32'(r_cfg.short_len);
            fdm_pkg::REG_SHORT_DIST: prdata = 32'(r_cfg.short_dist);
            fdm_pkg::REG_LONG_DIST:  prdata = 32'(r_cfg.long_dist);
            default:                 prdata = '0;
        endcase
    end

    fdm_front u_front (
        .i_item (i_item),
        .i_full (q_full),
        .o_wr   (wr)
    );

    fdm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    fdm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_item   (q_data),
        .i_empty  (q_empty),
        .o_pop    (q_pop),
        .o_result (o_result)
    );
endmodule
